// ----- hdl/kpd_pkg.sv -----
// ============================================================================
// kpd_pkg - shared types, constants and letter lookup
// Types and helpers used by the front end, request queue and back end of the
// multi-tap keypad decoder.
// ============================================================================
`default_nettype none

package kpd_pkg;

    // Default depth of the queue between front and back end.
    localparam int DEFAULT_QUEUE_DEPTH = 2;

    // Keypad symbol codes.
    localparam logic [3:0] KEY_ZERO  = 4'd0;
    localparam logic [3:0] KEY_ONE   = 4'd1;
    localparam logic [3:0] KEY_TWO   = 4'd2;
    localparam logic [3:0] KEY_SEVEN = 4'd7;
    localparam logic [3:0] KEY_NINE  = 4'd9;
    localparam logic [3:0] SEPARATOR = 4'd10;
    localparam logic [3:0] NO_KEY    = 4'd10;

    // Character codes and run limits.
    localparam logic [6:0] LETTER_A    = 7'd97;
    localparam logic [6:0] SPACE_CODE  = 7'd32;
    localparam logic [6:0] CASE_OFFSET = 7'd32;
    localparam logic [2:0] RUN_MAX     = 3'd7;

    // Input request: one keypad symbol.
    typedef struct packed {
        logic [3:0] symbol;
        logic       end_of_message;
    } sym_item_t;

    // Output request: one decoded character.
    typedef struct packed {
        logic [6:0] char_code;
        logic       invalid;
        logic       last;
    } chr_item_t;

    // One decoded character before the last flag is known.
    typedef struct packed {
        logic [6:0] char_code;
        logic       invalid;
    } res_t;

    // Work for the back end: one or two characters from a single symbol.
    typedef struct packed {
        logic two;
        res_t res0;
        res_t res1;
    } job_t;

    // Queue status seen by both ends.
    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

    // Letter selected by a run of presses on a digit key 2..9.
    function automatic res_t letter_of(input logic [3:0] key,
                                       input logic [2:0] run,
                                       input logic       caps);
        logic [4:0] first;
        logic [2:0] count;
        logic [2:0] idx;
        res_t       r;
        case (key)
            4'd2:    first = 5'd0;
            4'd3:    first = 5'd3;
            4'd4:    first = 5'd6;
            4'd5:    first = 5'd9;
            4'd6:    first = 5'd12;
            4'd7:    first = 5'd15;
            4'd8:    first = 5'd19;
            4'd9:    first = 5'd22;
            default: first = 5'd0;
        endcase
        count = (key == KEY_SEVEN || key == KEY_NINE) ? 3'd4 : 3'd3;
        r.invalid = (run > count);
        idx = r.invalid ? count : run;
        r.char_code = LETTER_A + {2'b00, first} + {4'b0000, idx} - 7'd1;
        if (caps)
        begin
            r.char_code = r.char_code - CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/kpd_front.sv -----
// ============================================================================
// kpd_front - symbol classification and decoder state
// Accepts keypad symbols, tracks the pending run and caps flag, and turns
// each symbol into a job of zero, one or two characters for the queue.
// ============================================================================
`default_nettype none

module kpd_front
    import kpd_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          sym_valid,
    output logic               sym_stall,
    input  wire sym_item_t     sym_data,
    input  wire queue_status_t qstat,
    output logic               push,
    output job_t               push_data
);

    logic [3:0] prev_reg, prev_next;
    logic [2:0] run_reg, run_next;
    logic       caps_reg, caps_next;

    logic       accept;
    logic [3:0] sym_c;
    logic       is_key;
    logic       is_repeat;
    logic       flush_now;
    logic       is_space;
    logic       eom_flush;
    logic [3:0] upd_prev;
    logic [2:0] upd_run;
    logic       upd_caps;
    res_t       flush_res;
    res_t       eom_res;
    res_t       space_res;

    // The queue alone decides whether a symbol can enter.
    assign sym_stall = qstat.full;
    assign accept    = sym_valid && !qstat.full;

    // Classify the symbol and work out the state it leaves behind.
    always_comb
    begin
        sym_c     = (sym_data.symbol > SEPARATOR) ? SEPARATOR : sym_data.symbol;
        is_key    = (sym_c inside {[KEY_TWO:KEY_NINE]});
        is_repeat = is_key && (sym_c == prev_reg) && (run_reg != 3'd0);
        flush_now = !is_repeat && (run_reg != 3'd0) &&
                    (prev_reg inside {[KEY_TWO:KEY_NINE]});
        is_space  = (sym_c == KEY_ZERO);
        flush_res = letter_of(prev_reg, run_reg, caps_reg);

        upd_prev = sym_c;
        upd_caps = caps_reg;
        if (is_repeat)
        begin
            upd_run = (run_reg == RUN_MAX) ? RUN_MAX : run_reg + 3'd1;
        end
        else if (is_key)
        begin
            upd_run = 3'd1;
            if (prev_reg != KEY_ONE)
            begin
                upd_caps = 1'b0;
            end
        end
        else
        begin
            upd_run = 3'd0;
            if (sym_c == KEY_ONE)
            begin
                upd_caps = 1'b1;
            end
        end

        // The end flag flushes whatever run is pending after this symbol.
        eom_flush = sym_data.end_of_message && (upd_run != 3'd0);
        eom_res   = letter_of(upd_prev, upd_run, upd_caps);
        space_res = '{char_code: SPACE_CODE, invalid: 1'b0};
    end

    // Build the job: pending letter first, then space or end-of-message letter.
    always_comb
    begin
        push_data.res0 = flush_now ? flush_res : (is_space ? space_res : eom_res);
        push_data.res1 = is_space ? space_res : eom_res;
        push_data.two  = flush_now && (is_space || eom_flush);
        push           = accept && (flush_now || is_space || eom_flush);
    end

    // Next decoder state; the end flag returns it to the reset values.
    always_comb
    begin
        prev_next = prev_reg;
        run_next  = run_reg;
        caps_next = caps_reg;
        if (accept)
        begin
            if (sym_data.end_of_message)
            begin
                prev_next = NO_KEY;
                run_next  = 3'd0;
                caps_next = 1'b0;
            end
            else
            begin
                prev_next = upd_prev;
                run_next  = upd_run;
                caps_next = upd_caps;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= NO_KEY;
            run_reg  <= 3'd0;
            caps_reg <= 1'b0;
        end
        else
        begin
            prev_reg <= prev_next;
            run_reg  <= run_next;
            caps_reg <= caps_next;
        end
    end

`ifndef SYNTHESIS
    // An accepted end flag leaves the decoder in its reset state.
    a_eom_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && sym_data.end_of_message) |=>
            (run_reg == 3'd0 && prev_reg == NO_KEY && !caps_reg))
        else $error("decoder state not cleared after end of message");

    // A pending run always belongs to a letter key.
    a_run_on_key: assert property (@(posedge clk) disable iff (!rst_n)
        (run_reg != 3'd0) |-> (prev_reg >= KEY_TWO && prev_reg <= KEY_NINE))
        else $error("pending run without a letter key");
`endif

endmodule

`default_nettype wire

// ----- hdl/kpd_queue.sv -----
// ============================================================================
// kpd_queue - job queue between front and back end
// A small circular buffer of decoded jobs so that each end can stall
// independently of the other.
// ============================================================================
`default_nettype none

module kpd_queue
    import kpd_pkg::*;
#(
    parameter int DEPTH = DEFAULT_QUEUE_DEPTH
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire job_t     push_data,
    input  wire logic     pop,
    output queue_status_t qstat,
    output job_t          head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign qstat.empty = (count_reg == CNT_W'(0));
    assign qstat.full  = (count_reg == CNT_W'(DEPTH));
    assign head        = mem[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Job storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTHESIS
    // The fill count never passes the depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    // The back end only takes jobs that are there.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qstat.empty)
        else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

// ----- hdl/kpd_back.sv -----
// ============================================================================
// kpd_back - character serializer and output register
// Takes jobs from the queue head and sends their one or two characters out,
// one per cycle while chr_stall is low, through a registered output stage.
// ============================================================================
`default_nettype none

module kpd_back
    import kpd_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire queue_status_t qstat,
    input  wire job_t          head,
    output logic               pop,
    output logic               chr_valid,
    input  wire logic          chr_stall,
    output chr_item_t          chr_data
);

    logic      sel_reg, sel_next;
    logic      valid_reg, valid_next;
    chr_item_t data_reg, data_next;

    logic load;
    logic take;
    logic is_last;
    res_t pick;

    assign chr_valid = valid_reg;
    assign chr_data  = data_reg;

    // Load the output register when it is empty or being drained.
    always_comb
    begin
        load    = !valid_reg || !chr_stall;
        take    = load && !qstat.empty;
        pick    = sel_reg ? head.res1 : head.res0;
        is_last = sel_reg || !head.two;
        pop     = take && is_last;

        sel_next   = sel_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        if (load)
        begin
            valid_next = !qstat.empty;
        end
        if (take)
        begin
            sel_next  = !is_last;
            data_next = '{char_code: pick.char_code, invalid: pick.invalid,
                          last: is_last};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            sel_reg   <= sel_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

`ifndef SYNTHESIS
    // The second character is only selected on a two-character job.
    a_sel_two: assert property (@(posedge clk) disable iff (!rst_n)
        sel_reg |-> (!qstat.empty && head.two))
        else $error("second character selected without a two-character job");

    // A taken non-final character is followed straight away by the next one.
    a_follow_on: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !chr_stall && !data_reg.last) |=> valid_reg)
        else $error("gap after a non-final character");
`endif

endmodule

`default_nettype wire

// ----- hdl/multi_tap_keypad_decoder_unit.sv -----
// ============================================================================
// multi_tap_keypad_decoder_unit - multi-tap keypad text decoder
// Decodes a stream of keypad symbols into ASCII letters and spaces.
// ============================================================================
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+-----------------------------
//  sym     | in        | sym_valid/sym_stall  | symbol, end_of_message
//  chr     | out       | chr_valid/chr_stall  | char_code, invalid, last
//
//  A symbol is accepted in any cycle in which the job queue has room, so a
//  new symbol can enter every cycle. The back end sends one character per
//  cycle while chr_stall is low; a symbol that yields two characters holds
//  the back end until both are sent. The first character of a symbol passes
//  through the job queue and then the output register.
//  Reset clears the decoder state, empties the queue and drops chr_valid.
//  Output stalls fill the queue and then raise sym_stall.
//
`default_nettype none

module multi_tap_keypad_decoder_unit
    import kpd_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      sym_valid,
    output logic           sym_stall,
    input  wire sym_item_t sym_data,
    output logic           chr_valid,
    input  wire logic      chr_stall,
    output chr_item_t      chr_data
);

    queue_status_t qstat;
    logic          push;
    job_t          push_data;
    logic          pop;
    job_t          head;

    // Front end: classification and decoder state.
    kpd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .sym_valid (sym_valid),
        .sym_stall (sym_stall),
        .sym_data  (sym_data),
        .qstat     (qstat),
        .push      (push),
        .push_data (push_data)
    );

    // Job queue between the two ends.
    kpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .qstat     (qstat),
        .head      (head)
    );

    // Back end: character serializer and output register.
    kpd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .qstat     (qstat),
        .head      (head),
        .pop       (pop),
        .chr_valid (chr_valid),
        .chr_stall (chr_stall),
        .chr_data  (chr_data)
    );

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// ============================================================================
// tb_top - self-checking bench for the multi-tap keypad decoder
// Sends keypad symbols through the sym channel and checks every character on
// the chr channel against a cycle-free model of the decoder held in the
// bench. Directed keys come first, then random messages of well-formed
// multi-tap words mixed with random noise, under random source gaps and
// random output stalls.
// ============================================================================
`default_nettype none

module tb_top
    import kpd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Run limits.
    localparam int IDLE_LIMIT   = 1000;
    localparam int TAIL_CYCLES  = 20;
    localparam int HOLD_AT      = 700;
    localparam int HOLD_CYCLES  = 90;
    localparam int REPORT_LIMIT = 10;

    // Output stall patterns.
    typedef enum logic [1:0] {
        RX_FREE,
        RX_COIN,
        RX_EVERY_FOURTH,
        RX_HEAVY
    } rx_mode_t;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      sym_valid = 1'b0;
    logic      sym_stall;
    sym_item_t sym_data  = '0;
    logic      chr_valid;
    logic      chr_stall = 1'b0;
    chr_item_t chr_data;

    // Pending symbols for the driver and characters the decoder still owes.
    sym_item_t key_queue[$];
    sym_item_t msg[$];
    chr_item_t chars_due[$];
    res_t      step_res[$];

    // Decoder model state.
    logic [3:0] held_key = NO_KEY;
    logic [2:0] run_len  = 3'd0;
    logic       caps_on  = 1'b0;

    // Handshake bookkeeping.
    logic     sym_took   = 1'b0;
    int       gap_left   = 0;
    int       burst_left = 0;
    int       hold_left  = 0;
    bit       hold_done  = 1'b0;
    int       mode_left  = 0;
    int       mode_tick  = 0;
    rx_mode_t stall_mode = RX_FREE;

    // Statistics and failures.
    int items_in        = 0;
    int chars_checked   = 0;
    int spaces_seen     = 0;
    int upper_seen      = 0;
    int overlong_seen   = 0;
    int pair_symbols    = 0;
    int eom_symbols     = 0;
    int in_stall_cycles = 0;
    int idle_cycles     = 0;
    int fail_count      = 0;

    multi_tap_keypad_decoder_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sym_valid (sym_valid),
        .sym_stall (sym_stall),
        .sym_data  (sym_data),
        .chr_valid (chr_valid),
        .chr_stall (chr_stall),
        .chr_data  (chr_data)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Emit the letter of the run in progress, if there is one.
    function void flush_letter();
        logic [6:0] key7;
        logic [6:0] base;
        logic [6:0] code;
        logic [2:0] span;
        logic [2:0] pos;
        logic       bad;
        if (run_len == 3'd0 || held_key < KEY_TWO || held_key > KEY_NINE)
        begin
            return;
        end
        key7 = {3'b000, held_key};
        span = (held_key == KEY_SEVEN || held_key == KEY_NINE) ? 3'd4 : 3'd3;
        // Keys 8 and 9 sit one letter further on because key 7 holds four.
        base = (key7 - 7'd2) * 7'd3 + ((held_key > KEY_SEVEN) ? 7'd1 : 7'd0);
        pos  = run_len;
        bad  = 1'b0;
        if (pos > span)
        begin
            pos = span;
            bad = 1'b1;
        end
        code = LETTER_A + base + {4'b0000, pos} - 7'd1;
        if (caps_on)
        begin
            code = code - CASE_OFFSET;
        end
        step_res.push_back('{char_code: code, invalid: bad});
    endfunction

    // Advance the decoder model by one symbol and queue the characters it owes.
    function void predict_chars(input sym_item_t it);
        logic [3:0] k;
        chr_item_t  c;
        step_res.delete();
        // Unused codes above the separator behave as the separator.
        k = (it.symbol > SEPARATOR) ? SEPARATOR : it.symbol;
        if (k >= KEY_TWO && k <= KEY_NINE)
        begin
            if (k == held_key && run_len != 3'd0)
            begin
                if (run_len < RUN_MAX)
                begin
                    run_len = run_len + 3'd1;
                end
            end
            else
            begin
                flush_letter();
                run_len = 3'd1;
                if (held_key != KEY_ONE)
                begin
                    caps_on = 1'b0;
                end
            end
        end
        else if (k == KEY_ONE)
        begin
            flush_letter();
            run_len = 3'd0;
            caps_on = 1'b1;
        end
        else if (k == KEY_ZERO)
        begin
            flush_letter();
            step_res.push_back('{char_code: SPACE_CODE, invalid: 1'b0});
            run_len = 3'd0;
        end
        else
        begin
            flush_letter();
            run_len = 3'd0;
        end
        held_key = k;

        // The end flag flushes after the symbol and clears everything.
        if (it.end_of_message)
        begin
            flush_letter();
            held_key = NO_KEY;
            run_len  = 3'd0;
            caps_on  = 1'b0;
            eom_symbols++;
        end

        if (step_res.size() == 2)
        begin
            pair_symbols++;
        end
        foreach (step_res[i])
        begin
            c.char_code = step_res[i].char_code;
            c.invalid   = step_res[i].invalid;
            c.last      = (i == step_res.size() - 1);
            chars_due.push_back(c);
        end
    endfunction

    function void add_key(input logic [3:0] s, input logic eom);
        sym_item_t it;
        it.symbol         = s;
        it.end_of_message = eom;
        msg.push_back(it);
    endfunction

    // Build one message of multi-tap words into msg.
    function void build_message();
        int         words;
        int         span;
        int         presses;
        logic [3:0] k;
        logic [3:0] run_key;
        msg.delete();
        words = $urandom_range(1, 4);
        for (int w = 0; w < words; w++)
        begin
            run_key = NO_KEY;
            if (w > 0)
            begin
                add_key(KEY_ZERO, 1'b0);
                if ($urandom_range(0, 5) == 0)
                begin
                    add_key(KEY_ZERO, 1'b0);
                end
            end
            repeat ($urandom_range(1, 6))
            begin
                k = 4'($urandom_range(2, 9));
                if ($urandom_range(0, 5) == 0)
                begin
                    add_key(KEY_ONE, 1'b0);
                    if ($urandom_range(0, 3) == 0)
                    begin
                        add_key(KEY_ONE, 1'b0);
                    end
                    run_key = KEY_ONE;
                end
                // Same key twice in a row needs a separator between letters.
                if (k == run_key)
                begin
                    if ($urandom_range(0, 4) == 0)
                    begin
                        add_key(4'($urandom_range(11, 15)), 1'b0);
                    end
                    else
                    begin
                        add_key(SEPARATOR, 1'b0);
                    end
                end
                span    = (k == KEY_SEVEN || k == KEY_NINE) ? 4 : 3;
                presses = ($urandom_range(0, 9) == 0) ? $urandom_range(span + 1, 9)
                                                        : $urandom_range(1, span);
                repeat (presses)
                begin
                    add_key(k, 1'b0);
                end
                run_key = k;
            end
        end
        // Most messages close with the end flag; the rest run into the next.
        if ($urandom_range(0, 9) < 7)
        begin
            msg[msg.size() - 1].end_of_message = 1'b1;
        end
    endfunction

    // Queue random traffic until target symbols are pending.
    task fill_random(input int target);
        int        made;
        sym_item_t it;
        made = 0;
        while (made < target)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                build_message();
                made = made + msg.size();
                foreach (msg[i])
                begin
                    key_queue.push_back(msg[i]);
                end
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                begin
                    it.symbol         = 4'($urandom_range(0, 15));
                    it.end_of_message = ($urandom_range(0, 7) == 0);
                    key_queue.push_back(it);
                    made++;
                end
            end
        end
    endtask

    task wait_drained();
        wait (key_queue.size() == 0 && !sym_valid);
        wait (chars_due.size() == 0);
    endtask

    // Source: sends in bursts with gaps, holds a stalled request unchanged.
    always @(negedge clk)
    begin
        if (rst_n && !(sym_valid && !sym_took))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                sym_valid <= 1'b0;
            end
            else if (key_queue.size() > 0)
            begin
                sym_data  <= key_queue.pop_front();
                sym_valid <= 1'b1;
                if (burst_left > 0)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60)
                                                            : $urandom_range(0, 10);
                    gap_left   = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 8);
                end
            end
            else
            begin
                sym_valid <= 1'b0;
            end
        end
    end

    // Sink: switches between stall patterns, with one long hold-off.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            mode_tick++;
            if (mode_left == 0)
            begin
                mode_left  = $urandom_range(16, 96);
                stall_mode = rx_mode_t'($urandom_range(0, 3));
            end
            else
            begin
                mode_left--;
            end
            if (!hold_done && items_in >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                chr_stall <= 1'b1;
            end
            else
            begin
                case (stall_mode)
                    RX_FREE:         chr_stall <= 1'b0;
                    RX_COIN:         chr_stall <= 1'($urandom_range(0, 1));
                    RX_EVERY_FOURTH: chr_stall <= (mode_tick % 4 == 3);
                    default:         chr_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // Monitor: model on accepted symbols, check accepted characters.
    always @(posedge clk)
    begin
        chr_item_t want;
        sym_took <= rst_n && sym_valid && !sym_stall;
        if (rst_n)
        begin
            if (sym_valid && !sym_stall)
            begin
                predict_chars(sym_data);
                items_in++;
            end
            if (sym_valid && sym_stall)
            begin
                in_stall_cycles++;
            end
            if (chr_valid && !chr_stall)
            begin
                chars_checked++;
                if (chars_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                    begin
                        $display("[%0t] unexpected character: code=%0d invalid=%0b last=%0b",
                                 $realtime, chr_data.char_code, chr_data.invalid,
                                 chr_data.last);
                    end
                end
                else
                begin
                    want = chars_due.pop_front();
                    if (chr_data.char_code !== want.char_code ||
                        chr_data.invalid !== want.invalid ||
                        chr_data.last !== want.last)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                        begin
                            $display("[%0t] mismatch: expected code=%0d invalid=%0b last=%0b, %s",
                                     $realtime, want.char_code, want.invalid, want.last,
                                     $sformatf("got code=%0d invalid=%0b last=%0b",
                                               chr_data.char_code, chr_data.invalid,
                                               chr_data.last));
                        end
                    end
                    if (want.char_code == SPACE_CODE)
                    begin
                        spaces_seen++;
                    end
                    else if (want.char_code < LETTER_A)
                    begin
                        upper_seen++;
                    end
                    if (want.invalid)
                    begin
                        overlong_seen++;
                    end
                end
            end
            if ((sym_valid && !sym_stall) || (chr_valid && !chr_stall))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
    end

    // Watchdog: no traffic for too long means the decoder hung.
    initial
    begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("No request moved for %0d cycles; %0d characters still owed.",
                 IDLE_LIMIT, chars_due.size());
        $display("Regression FAIL");
        $finish;
    end

    // Stimulus and end of run.
    initial
    begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // Directed keys: spaces, separators, caps, longest key, overlong runs.
        add_key(KEY_ZERO, 1'b0);          // space at start of message
        add_key(KEY_ZERO, 1'b0);          // space after a space
        add_key(SEPARATOR, 1'b0);         // separator with nothing pending
        add_key(KEY_TWO, 1'b0);
        add_key(4'd3, 1'b0);              // ends the run on key two
        add_key(4'd15, 1'b0);             // top unused code acts as separator
        add_key(KEY_ONE, 1'b0);
        add_key(KEY_ONE, 1'b0);           // second one keeps caps
        repeat (4) add_key(KEY_NINE, 1'b0);
        add_key(KEY_ZERO, 1'b0);          // letter and space from one symbol
        repeat (8) add_key(KEY_SEVEN, 1'b0);  // run saturates, flagged invalid
        add_key(4'd11, 1'b1);             // end flag behind an unused code
        add_key(4'd5, 1'b1);              // end flag flushes a fresh run
        add_key(KEY_ZERO, 1'b1);
        add_key(4'd12, 1'b1);
        foreach (msg[i])
        begin
            key_queue.push_back(msg[i]);
        end
        wait_drained();

        // Random traffic in two halves; the source rests in between.
        fill_random(940);
        wait_drained();
        repeat ($urandom_range(5, 30)) @(negedge clk);
        fill_random(940);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (chars_due.size() != 0)
        begin
            fail_count = fail_count + chars_due.size();
            $display("%0d characters never arrived.", chars_due.size());
        end
        $display("Sent %0d symbols (%0d with end flag, %0d giving two characters); %s",
                 items_in, eom_symbols, pair_symbols,
                 $sformatf("checked %0d characters.", chars_checked));
        $display("Seen %0d spaces, %0d capitals, %0d overlong runs; input stalled %0d cycles.",
                 spaces_seen, upper_seen, overlong_seen, in_stall_cycles);
        if (fail_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
